// File: rtl/voice_slot_allocator_gen_handles_top_defines.svh
// Assertion macros shared by the voice slot allocator RTL.
// Pulled in by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef VOICE_SLOT_ALLOCATOR_GEN_HANDLES_TOP_DEFINES_SVH
`define VOICE_SLOT_ALLOCATOR_GEN_HANDLES_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define VSA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define VSA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/vsa_pkg.sv
// Package for the voice slot allocator: sizes, request/status codes, command types.
// No dependencies; used by the front end, queue, back end and top level.
package vsa_pkg;

  localparam int MAX_TRACKS = 16;
  localparam int TRACK_CAP  = (MAX_TRACKS < 16) ? MAX_TRACKS : 16;
  localparam int TRK_IW     = (TRACK_CAP > 1) ? $clog2(TRACK_CAP) : 1;
  localparam int CNT_W      = $clog2(TRACK_CAP + 1);

  typedef logic [TRK_IW-1:0] idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam logic [2:0] REQ_PLAY  = 3'd0;
  localparam logic [2:0] REQ_EXT   = 3'd1;
  localparam logic [2:0] REQ_STOP  = 3'd2;
  localparam logic [2:0] REQ_REAP  = 3'd3;
  localparam logic [2:0] REQ_SWEEP = 3'd4;
  localparam logic [2:0] REQ_QUERY = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_OBJ   = 2'd1;
  localparam logic [1:0] ST_REJECTED  = 2'd2;
  localparam logic [1:0] ST_BAD_VOICE = 2'd3;

  localparam logic [15:0] GEN_RESET = 16'd1;

  typedef enum logic [2:0] {
    OP_PLAY,
    OP_PLAY_EXT,
    OP_BAD_OBJ,
    OP_STOP,
    OP_REAP,
    OP_SWEEP,
    OP_QUERY
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SUM
  } state_t;

  // One classified request as it sits in the queue.
  typedef struct packed {
    op_t         op;
    logic [31:0] object_handle;
    logic        voice_kind;
    logic [15:0] owner_id;
    logic [31:0] voice_in;
    logic        sink_accepts;
    logic [15:0] done_mask;
  } cmd_t;

  // Queue handshake toward the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qword_t;

  // One result word.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] voice_handle;
    logic [3:0]  track_index;
    logic [31:0] released_object;
    logic        release_valid;
    logic        is_stop_event;
    logic [4:0]  stopped_count;
    logic        voice_ok;
    logic [31:0] query_object;
    logic [4:0]  active_tracks;
    logic [4:0]  free_tracks;
    logic        last;
  } res_t;

endpackage

// File: rtl/vsa_in_if.sv
// Request channel interface for the voice slot allocator.
// Standalone; carries valid/ready and the request fields.
interface vsa_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] object_handle;
  logic        object_ok;
  logic        voice_kind;
  logic [15:0] owner_id;
  logic [31:0] voice_in;
  logic        sink_accepts;
  logic [15:0] done_mask;

  modport source (output valid, req_type, object_handle, object_ok, voice_kind,
                  owner_id, voice_in, sink_accepts, done_mask, input ready);
  modport sink (input valid, req_type, object_handle, object_ok, voice_kind,
                owner_id, voice_in, sink_accepts, done_mask, output ready);
endinterface

// File: rtl/vsa_out_if.sv
// Result channel interface for the voice slot allocator.
// Standalone; carries valid/ready and the result fields.
interface vsa_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] voice_handle;
  logic [3:0]  track_index;
  logic [31:0] released_object;
  logic        release_valid;
  logic        is_stop_event;
  logic [4:0]  stopped_count;
  logic        voice_ok;
  logic [31:0] query_object;
  logic [4:0]  active_tracks;
  logic [4:0]  free_tracks;
  logic        last;

  modport source (output valid, status, voice_handle, track_index, released_object,
                  release_valid, is_stop_event, stopped_count, voice_ok, query_object,
                  active_tracks, free_tracks, last, input ready);
  modport sink (input valid, status, voice_handle, track_index, released_object,
                release_valid, is_stop_event, stopped_count, voice_ok, query_object,
                active_tracks, free_tracks, last, output ready);
endinterface

// File: rtl/vsa_cfg_if.sv
// Configuration write channel for the voice slot allocator.
// Standalone; carries valid/ready and the tracks_in_use write data.
interface vsa_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] tracks_in_use;

  modport source (output valid, tracks_in_use, input ready);
  modport sink (input valid, tracks_in_use, output ready);
endinterface

// File: rtl/vsa_front.sv
// Front end: takes request words and classifies them into queue commands.
// Depends on vsa_pkg and vsa_in_if.
module vsa_front (
  vsa_in_if.sink         in_ch,
  input  logic           q_ready,
  output vsa_pkg::qword_t q_push
);

  vsa_pkg::op_t op;
  logic         known;

  always_comb begin
    op    = vsa_pkg::OP_PLAY;
    known = 1'b1;
    unique case (in_ch.req_type)
      vsa_pkg::REQ_PLAY: begin
        // bad object is decided here, before any track search
        op = (!in_ch.object_ok || in_ch.object_handle == 32'd0) ?
             vsa_pkg::OP_BAD_OBJ : vsa_pkg::OP_PLAY;
      end
      vsa_pkg::REQ_EXT:   op = vsa_pkg::OP_PLAY_EXT;
      vsa_pkg::REQ_STOP:  op = vsa_pkg::OP_STOP;
      vsa_pkg::REQ_REAP:  op = vsa_pkg::OP_REAP;
      vsa_pkg::REQ_SWEEP: op = vsa_pkg::OP_SWEEP;
      vsa_pkg::REQ_QUERY: op = vsa_pkg::OP_QUERY;
      default:            known = 1'b0;  // unused codes: dropped, no result
    endcase
  end

  assign in_ch.ready = q_ready;

  assign q_push.valid             = in_ch.valid && q_ready && known;
  assign q_push.cmd.op            = op;
  assign q_push.cmd.object_handle = in_ch.object_handle;
  assign q_push.cmd.voice_kind    = in_ch.voice_kind;
  assign q_push.cmd.owner_id      = in_ch.owner_id;
  assign q_push.cmd.voice_in      = in_ch.voice_in;
  assign q_push.cmd.sink_accepts  = in_ch.sink_accepts;
  assign q_push.cmd.done_mask     = in_ch.done_mask;

endmodule

// File: rtl/vsa_queue.sv
// Two-entry command queue between front and back end.
// Depends on vsa_pkg.
module vsa_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  vsa_pkg::qword_t push,
  output logic            push_ready,
  input  logic            pop,
  output vsa_pkg::qword_t head
);

  vsa_pkg::cmd_t mem_r [2];
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign do_pop     = pop && (cnt_r != 2'd0);
  assign head.valid = (cnt_r != 2'd0);
  assign head.cmd   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push.valid ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push.valid) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wp_r] <= push.cmd;
    end
  end

endmodule

// File: rtl/vsa_back.sv
// Back end: track table, command sequencer, config register and result register.
// Depends on vsa_pkg, vsa_out_if, vsa_cfg_if and the shared assertion macros.
`include "voice_slot_allocator_gen_handles_top_defines.svh"

module vsa_back (
  input  logic            clk,
  input  logic            rst_n,
  vsa_cfg_if.sink         cfg_ch,
  input  vsa_pkg::qword_t head,
  output logic            pop,
  vsa_out_if.source       out_ch
);

  localparam int CAP = vsa_pkg::TRACK_CAP;

  // track table
  logic                 active_r [CAP];
  logic [15:0]          gen_r    [CAP];
  logic [31:0]          obj_r    [CAP];
  logic                 kind_r   [CAP];
  logic [15:0]          owner_r  [CAP];
  vsa_pkg::cnt_t        live_r, live_nxt;

  logic [4:0]           tiu_r;
  vsa_pkg::cnt_t        n_open;

  vsa_pkg::state_t      state_r, state_nxt;
  vsa_pkg::cmd_t        cmd_r;
  vsa_pkg::cnt_t        scan_r, scan_nxt;
  vsa_pkg::cnt_t        count_r, count_nxt;

  vsa_pkg::res_t        res_r, em;
  logic                 ov_r, ov_nxt;
  logic                 em_valid;
  logic                 can_load;

  vsa_pkg::idx_t        rd_idx, res_idx, free_idx;
  logic                 free_found;
  logic [15:0]          low, lowm1;
  logic                 res_ok;
  logic                 hit;
  logic                 claim, free_en;
  logic [15:0]          gen_bump;
  logic [31:0]          rd_obj;

  // config register, to be written only while idle; the block itself does not enforce this
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tiu_r <= 5'd16;
    end else if (cfg_ch.valid) begin
      tiu_r <= cfg_ch.tracks_in_use;
    end
  end

  assign n_open = (tiu_r > 5'(CAP)) ? vsa_pkg::cnt_t'(CAP) : vsa_pkg::cnt_t'(tiu_r);

  // lowest free open track
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (!active_r[i] && (vsa_pkg::cnt_t'(i) < n_open)) begin
        free_idx   = vsa_pkg::idx_t'(i);
        free_found = 1'b1;
      end
    end
  end

  // handle decode
  assign low     = cmd_r.voice_in[15:0];
  assign lowm1   = low - 16'd1;
  assign res_idx = vsa_pkg::idx_t'(lowm1);

  // single table read port: scan pointer or resolved handle
  assign rd_idx = (state_r == vsa_pkg::S_SCAN) ? vsa_pkg::idx_t'(scan_r) : res_idx;
  assign rd_obj = obj_r[rd_idx];

  assign res_ok = (low != 16'd0) && (lowm1 < 16'(n_open)) && active_r[rd_idx] &&
                  (gen_r[rd_idx] == cmd_r.voice_in[31:16]);

  assign hit = active_r[rd_idx] &&
               ((cmd_r.op == vsa_pkg::OP_REAP) ?
                (!kind_r[rd_idx] && cmd_r.done_mask[rd_idx]) :
                (owner_r[rd_idx] == cmd_r.owner_id));

  always_comb begin
    gen_bump = gen_r[rd_idx] + 16'd1;
    if (gen_bump == 16'd0) begin
      gen_bump = 16'd1;
    end
  end

  assign can_load = !ov_r || out_ch.ready;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    count_nxt = count_r;
    pop       = 1'b0;
    claim     = 1'b0;
    free_en   = 1'b0;
    em_valid  = 1'b0;
    em        = '0;
    unique case (state_r)
      vsa_pkg::S_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          state_nxt = vsa_pkg::S_EXEC;
        end
      end
      vsa_pkg::S_EXEC: begin
        if (can_load) begin
          state_nxt = vsa_pkg::S_IDLE;
          unique case (cmd_r.op)
            vsa_pkg::OP_BAD_OBJ: begin
              em_valid  = 1'b1;
              em.status = vsa_pkg::ST_BAD_OBJ;
              em.last   = 1'b1;
            end
            vsa_pkg::OP_PLAY, vsa_pkg::OP_PLAY_EXT: begin
              em_valid = 1'b1;
              em.last  = 1'b1;
              if (free_found && cmd_r.sink_accepts) begin
                claim           = 1'b1;
                em.status       = vsa_pkg::ST_OK;
                em.voice_handle = {gen_r[free_idx], 16'(free_idx) + 16'd1};
                em.track_index  = 4'(free_idx);
              end else begin
                em.status = vsa_pkg::ST_REJECTED;
              end
            end
            vsa_pkg::OP_STOP: begin
              em_valid = 1'b1;
              if (res_ok) begin
                free_en            = 1'b1;
                em.track_index     = 4'(rd_idx);
                em.released_object = rd_obj;
                em.release_valid   = (rd_obj != 32'd0);
                em.is_stop_event   = 1'b1;
                count_nxt          = vsa_pkg::cnt_t'(1);
                state_nxt          = vsa_pkg::S_SUM;
              end else begin
                em.status = vsa_pkg::ST_BAD_VOICE;
                em.last   = 1'b1;
              end
            end
            vsa_pkg::OP_QUERY: begin
              em_valid        = 1'b1;
              em.voice_ok     = res_ok;
              em.query_object = res_ok ? rd_obj : 32'd0;
              em.last         = 1'b1;
            end
            vsa_pkg::OP_REAP, vsa_pkg::OP_SWEEP: begin
              scan_nxt  = '0;
              count_nxt = '0;
              state_nxt = vsa_pkg::S_SCAN;
            end
            default: ;
          endcase
        end
      end
      vsa_pkg::S_SCAN: begin
        if (can_load) begin
          if (scan_r >= n_open) begin
            em_valid         = 1'b1;
            em.stopped_count = 5'(count_r);
            em.last          = 1'b1;
            state_nxt        = vsa_pkg::S_IDLE;
          end else begin
            scan_nxt = scan_r + vsa_pkg::cnt_t'(1);
            if (hit) begin
              free_en            = 1'b1;
              em_valid           = 1'b1;
              em.track_index     = 4'(rd_idx);
              em.released_object = rd_obj;
              em.release_valid   = (rd_obj != 32'd0);
              em.is_stop_event   = 1'b1;
              count_nxt          = count_r + vsa_pkg::cnt_t'(1);
            end
          end
        end
      end
      vsa_pkg::S_SUM: begin
        if (can_load) begin
          em_valid         = 1'b1;
          em.stopped_count = 5'(count_r);
          em.last          = 1'b1;
          state_nxt        = vsa_pkg::S_IDLE;
        end
      end
      default: state_nxt = vsa_pkg::S_IDLE;
    endcase

    // live count after this step, reported on the result
    live_nxt = live_r;
    if (claim) begin
      live_nxt = live_r + vsa_pkg::cnt_t'(1);
    end else if (free_en && live_r != '0) begin
      live_nxt = live_r - vsa_pkg::cnt_t'(1);
    end
    em.active_tracks = 5'(live_nxt);
    em.free_tracks   = (n_open > live_nxt) ? 5'(n_open - live_nxt) : 5'd0;

    ov_nxt = em_valid ? 1'b1 : (out_ch.ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vsa_pkg::S_IDLE;
      live_r  <= '0;
      ov_r    <= 1'b0;
      scan_r  <= '0;
      count_r <= '0;
      for (int i = 0; i < CAP; i++) begin
        active_r[i] <= 1'b0;
        gen_r[i]    <= vsa_pkg::GEN_RESET;
      end
    end else begin
      state_r <= state_nxt;
      live_r  <= live_nxt;
      ov_r    <= ov_nxt;
      scan_r  <= scan_nxt;
      count_r <= count_nxt;
      if (claim) begin
        active_r[free_idx] <= 1'b1;
      end
      if (free_en) begin
        active_r[rd_idx] <= 1'b0;
        gen_r[rd_idx]    <= gen_bump;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= head.cmd;
    end
    if (em_valid) begin
      res_r <= em;
    end
    if (claim) begin
      obj_r[free_idx]   <= (cmd_r.op == vsa_pkg::OP_PLAY_EXT) ? 32'd0 : cmd_r.object_handle;
      kind_r[free_idx]  <= (cmd_r.op == vsa_pkg::OP_PLAY_EXT) ? 1'b1 : cmd_r.voice_kind;
      owner_r[free_idx] <= cmd_r.owner_id;
    end
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.status          = res_r.status;
  assign out_ch.voice_handle    = res_r.voice_handle;
  assign out_ch.track_index     = res_r.track_index;
  assign out_ch.released_object = res_r.released_object;
  assign out_ch.release_valid   = res_r.release_valid;
  assign out_ch.is_stop_event   = res_r.is_stop_event;
  assign out_ch.stopped_count   = res_r.stopped_count;
  assign out_ch.voice_ok        = res_r.voice_ok;
  assign out_ch.query_object    = res_r.query_object;
  assign out_ch.active_tracks   = res_r.active_tracks;
  assign out_ch.free_tracks     = res_r.free_tracks;
  assign out_ch.last            = res_r.last;

  `VSA_ASSERT_IMP(a_live_cap, 1'b1, live_r <= vsa_pkg::cnt_t'(CAP), "live count over capacity")
  `VSA_ASSERT_IMP(a_claim_free, claim, !active_r[free_idx] && !free_en, "claim of a busy track")
  `VSA_ASSERT_IMP(a_stop_not_last, em_valid && em.is_stop_event, !em.last,
                  "stop word flagged last")
  `VSA_ASSERT_NXT(a_pop_exec, pop, state_r == vsa_pkg::S_EXEC, "pop without execute")

endmodule

// File: rtl/voice_slot_allocator_gen_handles_top.sv
// Top level of the generational-handle voice slot allocator.
// Depends on vsa_pkg, the channel interfaces, vsa_front, vsa_queue and vsa_back.
//
// Usage:
//   in_ch  : request words (play, external play, stop, reap, sweep, query).
//            Unused request codes are taken and dropped without a result.
//   out_ch : result words; every request ends with one word flagged last.
//            Stop, reap and sweep send one stop word per freed track first.
//   cfg_ch : writes tracks_in_use; write only while the block is idle.
//            cfg_ch.ready is always high.
// A request taken by an idle block passes the queue, the pop into the sequencer
//   and the result register before out_ch.valid rises. The sequencer finishes one
//   request before it pops the next: play, query and bad-handle stop pass idle and
//   execute, a good stop adds a summary word, and reap and sweep scan every open
//   track, one table read per cycle via the single track read port unless stalled.
// A two-entry queue keeps taking requests while the back end works or a
//   result waits; if the receiver stalls, the result word holds, the
//   sequencer waits and requests back up to in_ch.ready.
// Reset (rst_n low, synchronous): all tracks free, generations at 1,
//   live count 0, tracks_in_use 16, queue and output empty.
module voice_slot_allocator_gen_handles_top (
  input  logic      clk,
  input  logic      rst_n,
  vsa_in_if.sink    in_ch,
  vsa_out_if.source out_ch,
  vsa_cfg_if.sink   cfg_ch
);

  vsa_pkg::qword_t q_push;
  vsa_pkg::qword_t q_head;
  logic            q_ready;
  logic            q_pop;

  // classify and enqueue
  vsa_front u_front (
    .in_ch  (in_ch),
    .q_ready(q_ready),
    .q_push (q_push)
  );

  // decouples intake from execution
  vsa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_ready(q_ready),
    .pop       (q_pop),
    .head      (q_head)
  );

  // track table, sequencer and result register
  vsa_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .head  (q_head),
    .pop   (q_pop),
    .out_ch(out_ch)
  );

endmodule

// File: test/voice_slot_allocator_gen_handles_top_tb.sv
// Self-checking bench for voice_slot_allocator_gen_handles_top: directed corner requests,
// then random request traffic over several track-count settings, against a track table model.
// Needs vsa_pkg and the vsa_in_if / vsa_out_if / vsa_cfg_if channel interfaces.
module voice_slot_allocator_gen_handles_top_tb;

  // Run sizing. The cycle limit assumes the worst case: every request giving
  // a full 17-word stream, each word held through the longest receiver stall.
  localparam int RANDOM_ITEMS = 460;
  localparam int PHASES       = 6;
  localparam int IDLE_TAIL    = 24;      // request latency + a full 16-track scan + margin
  localparam int SETTLE_BOUND = 20000;
  localparam int MAX_STALL    = 20;
  localparam int CYCLE_LIMIT  = 1000000;

  // Request codes the block must swallow without a result word.
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;

  // One request word as it crosses in_ch.
  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] object_handle;
    logic        object_ok;
    logic        voice_kind;
    logic [15:0] owner_id;
    logic [31:0] voice_in;
    logic        sink_accepts;
    logic [15:0] done_mask;
  } req_word_t;

  typedef enum logic [1:0] {RX_STEADY, RX_CHOPPY, RX_BLOCKED} rx_mode_t;

  // Track table model: mirrors the allocator state and queues the result
  // words each accepted request must produce, in order.
  class track_table_model;
    logic [4:0]    tracks_in_use;
    logic          busy [vsa_pkg::TRACK_CAP];
    logic [31:0]   track_obj [vsa_pkg::TRACK_CAP];
    logic          track_music [vsa_pkg::TRACK_CAP];
    logic [15:0]   track_owner [vsa_pkg::TRACK_CAP];
    logic [15:0]   track_gen [vsa_pkg::TRACK_CAP];
    int            live;
    vsa_pkg::res_t expected_words [$];
    logic [31:0]   retired_handles [$];
    string         diff_text;
    int            mismatches;
    int            words_checked;
    int            requests_seen;
    int            stop_words;

    function new();
      tracks_in_use = 5'd16;
      for (int t = 0; t < vsa_pkg::TRACK_CAP; t++) begin
        busy[t]        = 1'b0;
        track_obj[t]   = 32'd0;
        track_music[t] = 1'b0;
        track_owner[t] = 16'd0;
        track_gen[t]   = vsa_pkg::GEN_RESET;
      end
      live          = 0;
      mismatches    = 0;
      words_checked = 0;
      requests_seen = 0;
      stop_words    = 0;
    endfunction

    function void set_tracks(logic [4:0] v);
      tracks_in_use = v;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Register value clamped to what the block is built with.
    function int open_count();
      int n;
      n = int'(tracks_in_use);
      return (n > vsa_pkg::TRACK_CAP) ? vsa_pkg::TRACK_CAP : n;
    endfunction

    // Occupancy fields reflect the table after the word's own effect.
    function vsa_pkg::res_t make_word(logic [1:0] status, logic [31:0] handle, int trk,
                                      logic [31:0] rel, logic stop_ev, int cnt, logic vok,
                                      logic [31:0] qobj, logic last);
      vsa_pkg::res_t w;
      int            n;
      n = open_count();
      w.status          = status;
      w.voice_handle    = handle;
      w.track_index     = 4'(trk);
      w.released_object = rel;
      w.release_valid   = (rel != 32'd0);
      w.is_stop_event   = stop_ev;
      w.stopped_count   = 5'(cnt);
      w.voice_ok        = vok;
      w.query_object    = qobj;
      w.active_tracks   = 5'(live);
      w.free_tracks     = (n > live) ? 5'(n - live) : 5'd0;
      w.last            = last;
      return w;
    endfunction

    // Handle lookup: zero low half, out-of-range, idle or stale all miss.
    function int resolve(logic [31:0] v);
      int t;
      if (v[15:0] == 16'd0) return -1;
      t = int'(v[15:0]) - 1;
      if (t >= open_count()) return -1;
      if (!busy[t]) return -1;
      if (track_gen[t] != v[31:16]) return -1;
      return t;
    endfunction

    // Release a track: new generation (skipping zero), one stop word.
    function void free_slot(int t);
      logic [31:0] obj;
      logic [15:0] g;
      obj = track_obj[t];
      retired_handles.push_back({track_gen[t], 16'(t + 1)});
      if (retired_handles.size() > 16) void'(retired_handles.pop_front());
      g = track_gen[t] + 16'd1;
      if (g == 16'd0) g = 16'd1;
      track_gen[t]   = g;
      busy[t]        = 1'b0;
      track_obj[t]   = 32'd0;
      track_music[t] = 1'b0;
      track_owner[t] = 16'd0;
      if (live > 0) live--;
      expected_words.push_back(make_word(vsa_pkg::ST_OK, 32'd0, t, obj, 1'b1, 0, 1'b0,
                                         32'd0, 1'b0));
    endfunction

    function void note_request(req_word_t r);
      int   n;
      int   t;
      int   hits;
      logic hit;
      n = open_count();
      requests_seen++;
      case (r.req_type)
        vsa_pkg::REQ_PLAY, vsa_pkg::REQ_EXT: begin
          if (r.req_type == vsa_pkg::REQ_PLAY &&
              (!r.object_ok || r.object_handle == 32'd0)) begin
            expected_words.push_back(make_word(vsa_pkg::ST_BAD_OBJ, 32'd0, 0, 32'd0, 1'b0,
                                               0, 1'b0, 32'd0, 1'b1));
          end else begin
            t = 0;
            while (t < n && busy[t]) t++;
            if (t >= n || !r.sink_accepts) begin
              expected_words.push_back(make_word(vsa_pkg::ST_REJECTED, 32'd0, 0, 32'd0,
                                                 1'b0, 0, 1'b0, 32'd0, 1'b1));
            end else begin
              busy[t]        = 1'b1;
              track_obj[t]   = (r.req_type == vsa_pkg::REQ_EXT) ? 32'd0 : r.object_handle;
              track_music[t] = (r.req_type == vsa_pkg::REQ_EXT) ? 1'b1 : r.voice_kind;
              track_owner[t] = r.owner_id;
              live++;
              expected_words.push_back(make_word(vsa_pkg::ST_OK, {track_gen[t], 16'(t + 1)},
                                                 t, 32'd0, 1'b0, 0, 1'b0, 32'd0, 1'b1));
            end
          end
        end
        vsa_pkg::REQ_STOP: begin
          t = resolve(r.voice_in);
          if (t < 0) begin
            expected_words.push_back(make_word(vsa_pkg::ST_BAD_VOICE, 32'd0, 0, 32'd0, 1'b0,
                                               0, 1'b0, 32'd0, 1'b1));
          end else begin
            free_slot(t);
            expected_words.push_back(make_word(vsa_pkg::ST_OK, 32'd0, 0, 32'd0, 1'b0, 1,
                                               1'b0, 32'd0, 1'b1));
          end
        end
        vsa_pkg::REQ_REAP, vsa_pkg::REQ_SWEEP: begin
          hits = 0;
          for (t = 0; t < n; t++) begin
            if (busy[t]) begin
              if (r.req_type == vsa_pkg::REQ_REAP) hit = !track_music[t] && r.done_mask[t];
              else hit = (track_owner[t] == r.owner_id);
              if (hit) begin
                free_slot(t);
                hits++;
              end
            end
          end
          expected_words.push_back(make_word(vsa_pkg::ST_OK, 32'd0, 0, 32'd0, 1'b0, hits,
                                             1'b0, 32'd0, 1'b1));
        end
        vsa_pkg::REQ_QUERY: begin
          t = resolve(r.voice_in);
          if (t < 0)
            expected_words.push_back(make_word(vsa_pkg::ST_OK, 32'd0, 0, 32'd0, 1'b0, 0,
                                               1'b0, 32'd0, 1'b1));
          else
            expected_words.push_back(make_word(vsa_pkg::ST_OK, 32'd0, 0, 32'd0, 1'b0, 0,
                                               1'b1, track_obj[t], 1'b1));
        end
        default: ;  // spare codes: dropped silently
      endcase
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %0d:%s", mismatches, msg);
    endfunction

    function void note_diff(string f, logic [31:0] e, logic [31:0] a);
      if (e !== a) diff_text = {diff_text, $sformatf(" %s exp %0h got %0h", f, e, a)};
    endfunction

    function void check_word(vsa_pkg::res_t got);
      vsa_pkg::res_t want;
      words_checked++;
      if (got.is_stop_event === 1'b1) stop_words++;
      if (expected_words.size() == 0) begin
        report($sformatf(" unexpected word: status %0d track %0d last %0b",
                         got.status, got.track_index, got.last));
        return;
      end
      want = expected_words.pop_front();
      diff_text = "";
      note_diff("status", 32'(want.status), 32'(got.status));
      note_diff("voice_handle", want.voice_handle, got.voice_handle);
      note_diff("track_index", 32'(want.track_index), 32'(got.track_index));
      note_diff("released_object", want.released_object, got.released_object);
      note_diff("release_valid", 32'(want.release_valid), 32'(got.release_valid));
      note_diff("is_stop_event", 32'(want.is_stop_event), 32'(got.is_stop_event));
      note_diff("stopped_count", 32'(want.stopped_count), 32'(got.stopped_count));
      note_diff("voice_ok", 32'(want.voice_ok), 32'(got.voice_ok));
      note_diff("query_object", want.query_object, got.query_object);
      note_diff("active_tracks", 32'(want.active_tracks), 32'(got.active_tracks));
      note_diff("free_tracks", 32'(want.free_tracks), 32'(got.free_tracks));
      note_diff("last", 32'(want.last), 32'(got.last));
      if (diff_text != "") report({" word ", $sformatf("%0d", words_checked), diff_text});
    endfunction

    // A handle that is live right now, as far as the table knows.
    function logic [31:0] live_handle();
      int cand [$];
      int n;
      int t;
      n = open_count();
      for (t = 0; t < n; t++) if (busy[t]) cand.push_back(t);
      if (cand.size() == 0) return $urandom;
      t = cand[$urandom_range(0, cand.size() - 1)];
      return {track_gen[t], 16'(t + 1)};
    endfunction

    // A handle that used to be live and has since gone stale.
    function logic [31:0] retired_handle();
      if (retired_handles.size() == 0) return $urandom;
      return retired_handles[$urandom_range(0, retired_handles.size() - 1)];
    endfunction
  endclass

  logic clk;
  logic rst_n;

  vsa_in_if  in_ch();
  vsa_out_if out_ch();
  vsa_cfg_if cfg_ch();

  voice_slot_allocator_gen_handles_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  track_table_model tm;
  int       cycle_count = 0;
  int       settings_applied = 0;
  int       stall_left = 0;
  int       rx_timer = 0;
  rx_mode_t rx_mode = RX_STEADY;

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, tm.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: alternates between steady, choppy and long-stall stretches so
  // backpressure lands on single words, mid-scan streams and summaries alike.
  always @(posedge clk) begin
    if (rx_timer == 0) begin
      rx_timer <= $urandom_range(80, 300);
      case ($urandom_range(0, 2))
        0:       rx_mode <= RX_STEADY;
        1:       rx_mode <= RX_CHOPPY;
        default: rx_mode <= RX_BLOCKED;
      endcase
    end else begin
      rx_timer <= rx_timer - 1;
    end
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (rx_mode == RX_CHOPPY && $urandom_range(0, 2) == 0)
        stall_left <= $urandom_range(1, 3);
      else if (rx_mode == RX_BLOCKED && $urandom_range(0, 9) == 0)
        stall_left <= $urandom_range(4, MAX_STALL);
    end
  end

  // Monitor: sample all three channels at the edge (pre-update values), so
  // the model sees requests, config writes and result words in true order.
  always @(posedge clk) begin
    req_word_t     r;
    vsa_pkg::res_t w;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        tm.set_tracks(cfg_ch.tracks_in_use);
        settings_applied++;
      end
      if (in_ch.valid && in_ch.ready) begin
        r.req_type      = in_ch.req_type;
        r.object_handle = in_ch.object_handle;
        r.object_ok     = in_ch.object_ok;
        r.voice_kind    = in_ch.voice_kind;
        r.owner_id      = in_ch.owner_id;
        r.voice_in      = in_ch.voice_in;
        r.sink_accepts  = in_ch.sink_accepts;
        r.done_mask     = in_ch.done_mask;
        tm.note_request(r);
      end
      if (out_ch.valid && out_ch.ready) begin
        w.status          = out_ch.status;
        w.voice_handle    = out_ch.voice_handle;
        w.track_index     = out_ch.track_index;
        w.released_object = out_ch.released_object;
        w.release_valid   = out_ch.release_valid;
        w.is_stop_event   = out_ch.is_stop_event;
        w.stopped_count   = out_ch.stopped_count;
        w.voice_ok        = out_ch.voice_ok;
        w.query_object    = out_ch.query_object;
        w.active_tracks   = out_ch.active_tracks;
        w.free_tracks     = out_ch.free_tracks;
        w.last            = out_ch.last;
        tm.check_word(w);
      end
    end
  end

  function automatic req_word_t mk_req(logic [2:0] code, logic [31:0] obj, logic ok,
                                       logic music, logic [15:0] owner, logic [31:0] vin,
                                       logic accept, logic [15:0] mask);
    req_word_t r;
    r.req_type      = code;
    r.object_handle = obj;
    r.object_ok     = ok;
    r.voice_kind    = music;
    r.owner_id      = owner;
    r.voice_in      = vin;
    r.sink_accepts  = accept;
    r.done_mask     = mask;
    return r;
  endfunction

  // Owners cluster on a few values so sweeps actually catch several tracks.
  function automatic logic [15:0] pick_owner();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'h0001;
      3, 4:    return 16'h0002;
      5:       return 16'h0003;
      6:       return 16'h0000;
      7:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Handle mix for stop/query: mostly live, some stale, some junk.
  function automatic logic [31:0] pick_handle();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: return tm.live_handle();
      7, 8:                return tm.retired_handle();
      default:             return $urandom;
    endcase
  endfunction

  // Unused fields carry noise on purpose; the block must ignore them.
  function automatic req_word_t random_request();
    req_word_t r;
    int        pick;
    r.object_handle = $urandom;
    r.object_ok     = ($urandom_range(0, 9) != 0);
    r.voice_kind    = 1'($urandom_range(0, 1));
    r.owner_id      = pick_owner();
    r.voice_in      = $urandom;
    r.sink_accepts  = ($urandom_range(0, 9) != 0);
    r.done_mask     = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      r.req_type = vsa_pkg::REQ_PLAY;
      if (pick < 2) r.object_handle = 32'd0;
    end else if (pick < 43) begin
      r.req_type = vsa_pkg::REQ_EXT;
    end else if (pick < 63) begin
      r.req_type = vsa_pkg::REQ_STOP;
      r.voice_in = pick_handle();
    end else if (pick < 71) begin
      r.req_type = vsa_pkg::REQ_REAP;
      if (pick < 65) r.done_mask = 16'hFFFF;
    end else if (pick < 79) begin
      r.req_type = vsa_pkg::REQ_SWEEP;
    end else if (pick < 97) begin
      r.req_type = vsa_pkg::REQ_QUERY;
      r.voice_in = pick_handle();
    end else begin
      r.req_type = (pick == 99) ? REQ_SPARE_B : REQ_SPARE_A;
    end
    return r;
  endfunction

  // Present one word and hold it until the edge where it is taken.
  task automatic send_word(input req_word_t r);
    in_ch.req_type      <= r.req_type;
    in_ch.object_handle <= r.object_handle;
    in_ch.object_ok     <= r.object_ok;
    in_ch.voice_kind    <= r.voice_kind;
    in_ch.owner_id      <= r.owner_id;
    in_ch.voice_in      <= r.voice_in;
    in_ch.sink_accepts  <= r.sink_accepts;
    in_ch.done_mask     <= r.done_mask;
    in_ch.valid         <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Wait until every expected word is in, then let trailing dropped
  // requests or a scan drain before touching the register.
  task automatic settle(input int tail);
    int waited;
    in_ch.valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (tm.pending() != 0 && waited < SETTLE_BOUND) begin
      @(posedge clk);
      waited++;
    end
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_tracks(input logic [4:0] v);
    cfg_ch.tracks_in_use <= v;
    cfg_ch.valid         <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random traffic in bursts; gaps range from none to long enough to let
  // the block go fully idle.
  task automatic run_random(input int count);
    int        sent;
    int        burst;
    int        gap;
    req_word_t r;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        r = random_request();
        send_word(r);
        if (r.req_type != REQ_SPARE_A && r.req_type != REQ_SPARE_B) sent++;
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: gap = 0;
        5, 6, 7:       gap = $urandom_range(10, 30);
        default:       gap = $urandom_range(1, 5);
      endcase
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    int          leftover;
    logic [4:0]  phase_tracks [PHASES];
    tm = new();
    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.req_type       = vsa_pkg::REQ_PLAY;
    in_ch.object_handle  = 32'd0;
    in_ch.object_ok      = 1'b0;
    in_ch.voice_kind     = 1'b0;
    in_ch.owner_id       = 16'd0;
    in_ch.voice_in       = 32'd0;
    in_ch.sink_accepts   = 1'b0;
    in_ch.done_mask      = 16'd0;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.tracks_in_use = 5'd16;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting, all 16 tracks open, generations at 1.
    send_word(mk_req(vsa_pkg::REQ_PLAY, 32'h1234_5678, 1'b0, 1'b0, 16'h0001, 32'd0, 1'b1,
                     16'd0));
    send_word(mk_req(vsa_pkg::REQ_PLAY, 32'd0, 1'b1, 1'b0, 16'h0001, 32'd0, 1'b1, 16'd0));
    send_word(mk_req(vsa_pkg::REQ_PLAY, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'hFFFF, 32'hFFFF_FFFF,
                     1'b1, 16'hFFFF));
    // sink says no: nothing claimed
    send_word(mk_req(vsa_pkg::REQ_PLAY, 32'h0000_0001, 1'b1, 1'b1, 16'h0002, 32'd0, 1'b0,
                     16'd0));
    // external music ignores the object fields entirely
    send_word(mk_req(vsa_pkg::REQ_EXT, 32'hDEAD_BEEF, 1'b0, 1'b0, 16'h0000, 32'd0, 1'b1,
                     16'd0));
    send_word(mk_req(vsa_pkg::REQ_QUERY, 32'd0, 1'b0, 1'b0, 16'd0, 32'h0001_0001, 1'b0,
                     16'd0));
    send_word(mk_req(vsa_pkg::REQ_QUERY, 32'd0, 1'b0, 1'b0, 16'd0, 32'h0000_0000, 1'b0,
                     16'd0));
    // bad handles: zero low half, track past the end, idle track, wrong generation
    send_word(mk_req(vsa_pkg::REQ_STOP, 32'd0, 1'b0, 1'b0, 16'd0, 32'hFFFF_0000, 1'b0,
                     16'd0));
    send_word(mk_req(vsa_pkg::REQ_STOP, 32'd0, 1'b0, 1'b0, 16'd0, 32'h0001_0011, 1'b0,
                     16'd0));
    send_word(mk_req(vsa_pkg::REQ_STOP, 32'd0, 1'b0, 1'b0, 16'd0, 32'h0001_0005, 1'b0,
                     16'd0));
    send_word(mk_req(vsa_pkg::REQ_STOP, 32'd0, 1'b0, 1'b0, 16'd0, 32'h0002_0001, 1'b0,
                     16'd0));
    // good stop, then the same handle again is stale
    send_word(mk_req(vsa_pkg::REQ_STOP, 32'd0, 1'b0, 1'b0, 16'd0, 32'h0001_0001, 1'b0,
                     16'd0));
    send_word(mk_req(vsa_pkg::REQ_STOP, 32'd0, 1'b0, 1'b0, 16'd0, 32'h0001_0001, 1'b0,
                     16'd0));
    send_word(mk_req(REQ_SPARE_A, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                     16'hFFFF));
    send_word(mk_req(REQ_SPARE_B, 32'd0, 1'b0, 1'b0, 16'd0, 32'd0, 1'b0, 16'd0));
    settle(IDLE_TAIL);

    // Two tracks: fill up, get rejected, reap the effect but not the music.
    write_tracks(5'd2);
    send_word(mk_req(vsa_pkg::REQ_PLAY, 32'h8000_0000, 1'b1, 1'b0, 16'h0000, 32'd0, 1'b1,
                     16'd0));
    send_word(mk_req(vsa_pkg::REQ_PLAY, 32'h0000_0002, 1'b1, 1'b0, 16'h0000, 32'd0, 1'b1,
                     16'd0));
    send_word(mk_req(vsa_pkg::REQ_REAP, 32'd0, 1'b0, 1'b0, 16'd0, 32'd0, 1'b0, 16'hFFFF));
    settle(IDLE_TAIL);

    // One track: the music on track 1 now sits past the open range.
    write_tracks(5'd1);
    send_word(mk_req(vsa_pkg::REQ_PLAY, 32'h0000_0100, 1'b1, 1'b0, 16'h0000, 32'd0, 1'b1,
                     16'd0));
    send_word(mk_req(vsa_pkg::REQ_EXT, 32'd0, 1'b0, 1'b0, 16'h0000, 32'd0, 1'b1, 16'd0));
    send_word(mk_req(vsa_pkg::REQ_QUERY, 32'd0, 1'b0, 1'b0, 16'd0, 32'h0001_0002, 1'b0,
                     16'd0));
    send_word(mk_req(vsa_pkg::REQ_SWEEP, 32'd0, 1'b0, 1'b0, 16'h0000, 32'd0, 1'b0, 16'd0));
    settle(IDLE_TAIL);

    // No track open at all.
    write_tracks(5'd0);
    send_word(mk_req(vsa_pkg::REQ_PLAY, 32'h0000_0003, 1'b1, 1'b0, 16'h0001, 32'd0, 1'b1,
                     16'd0));
    send_word(mk_req(vsa_pkg::REQ_STOP, 32'd0, 1'b0, 1'b0, 16'd0, 32'h0001_0002, 1'b0,
                     16'd0));
    settle(IDLE_TAIL);

    // Oversized value clamps to 16; empty reap, then sweep picks up the music.
    write_tracks(5'd31);
    send_word(mk_req(vsa_pkg::REQ_REAP, 32'd0, 1'b0, 1'b0, 16'd0, 32'd0, 1'b0, 16'h0000));
    send_word(mk_req(vsa_pkg::REQ_SWEEP, 32'd0, 1'b0, 1'b0, 16'h0000, 32'd0, 1'b0, 16'd0));
    settle(IDLE_TAIL);

    // Random phases, each at its own track count, extremes included.
    phase_tracks[0] = 5'd16;
    phase_tracks[1] = 5'd1;
    phase_tracks[2] = 5'($urandom_range(2, 15));
    phase_tracks[3] = 5'd16;
    phase_tracks[4] = 5'($urandom_range(2, 15));
    phase_tracks[5] = 5'd16;
    for (int p = 0; p < PHASES; p++) begin
      write_tracks(phase_tracks[p]);
      run_random(RANDOM_ITEMS / PHASES);
      settle(IDLE_TAIL);
    end

    leftover = tm.pending();
    if (leftover != 0) $display("%0d expected words never arrived", leftover);
    $display("covered %0d requests over %0d track-count settings in %0d cycles",
             tm.requests_seen, settings_applied, cycle_count);
    $display("checked %0d result words, %0d of them stop words, %0d mismatches",
             tm.words_checked, tm.stop_words, tm.mismatches);
    if (tm.mismatches == 0 && leftover == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
